/* rtl/core/ulcm_pkg.sv */
// Package for the LED command matcher: constants, the command table,
// the result item type and the byte compare function.
// Depends on nothing; ulcm_in_stage, ulcm_line_core, ulcm_out_queue and the top level import it.
package ulcm_pkg;

  localparam int LINE_MAX_DEF = 10;
  localparam int CMD_COUNT    = 6;
  localparam int CMD_WORD_MAX = 9;

  typedef logic [7:0] char_t;

  localparam char_t CH_CR    = 8'd13;
  localparam char_t CH_LF    = 8'd10;
  localparam char_t CH_SPACE = 8'd32;
  localparam char_t CASE_BIT = 8'h20;

  localparam logic [2:0] LED_RED   = 3'd1;
  localparam logic [2:0] LED_BLUE  = 3'd2;
  localparam logic [2:0] LED_GREEN = 3'd4;

  localparam char_t CMD_TEXT [CMD_COUNT][CMD_WORD_MAX] = '{
    '{"o", "n", CH_SPACE, "r", "e", "d", 8'h00, 8'h00, 8'h00},
    '{"o", "n", CH_SPACE, "b", "l", "u", "e", 8'h00, 8'h00},
    '{"o", "n", CH_SPACE, "g", "r", "e", "e", "n", 8'h00},
    '{"o", "f", "f", CH_SPACE, "r", "e", "d", 8'h00, 8'h00},
    '{"o", "f", "f", CH_SPACE, "b", "l", "u", "e", 8'h00},
    '{"o", "f", "f", CH_SPACE, "g", "r", "e", "e", "n"}
  };

  localparam int CMD_LEN [CMD_COUNT] = '{6, 7, 8, 7, 8, 9};

  localparam logic [2:0] CMD_MASK [CMD_COUNT] = '{
    LED_RED, LED_BLUE, LED_GREEN, LED_RED, LED_BLUE, LED_GREEN
  };

  localparam logic CMD_ON [CMD_COUNT] = '{1'b1, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0};

  typedef struct packed {
    char_t out_byte;
    logic  led_red;
    logic  led_blue;
    logic  led_green;
    logic  last;
  } ulcm_result_t;

  typedef struct packed {
    logic [1:0]   n;
    ulcm_result_t first;
    ulcm_result_t second;
  } ulcm_push_t;

  // Letters in the pattern match in either case; anything else must be exact.
  function automatic logic byte_fits(input char_t b, input char_t p);
    logic fit;
    if (p inside {["a":"z"]}) begin
      fit = ((b | CASE_BIT) == p);
    end else begin
      fit = (b == p);
    end
    return fit;
  endfunction

endpackage

/* rtl/core/ulcm_in_if.sv */
// Channel carrying one received byte per item.
// Depends on nothing.
interface ulcm_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

/* rtl/core/ulcm_out_if.sv */
// Channel carrying one transmit byte and the LED drive per item.
// Depends on nothing.
interface ulcm_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       led_red;
  logic       led_blue;
  logic       led_green;
  logic       last;

  modport source (output valid, output out_byte, output led_red, output led_blue,
                  output led_green, output last, input ready);
  modport sink (input valid, input out_byte, input led_red, input led_blue,
                input led_green, input last, output ready);
endinterface

/* rtl/core/ulcm_in_stage.sv */
// Input register for received bytes.
// Depends on ulcm_pkg.
module ulcm_in_stage import ulcm_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  output logic  in_ready,
  input  char_t in_byte,
  input  logic  take,
  output logic  item_valid,
  output char_t item_byte
);

  logic  valid;
  char_t data;

  assign in_ready   = !valid || take;
  assign item_valid = valid;
  assign item_byte  = data;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_valid && in_ready) begin
      valid <= 1'b1;
    end else if (take) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      data <= in_byte;
    end
  end

endmodule

/* rtl/core/ulcm_line_core.sv */
// Line buffer, write position and LED state; matches the finished line
// against the command table and forms the echo and line feed results.
// Depends on ulcm_pkg.
module ulcm_line_core import ulcm_pkg::*; #(
  parameter int LINE_MAX = LINE_MAX_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       item_valid,
  input  char_t      item_byte,
  input  logic [1:0] free,
  output logic       take,
  output ulcm_push_t push
);

  localparam int POS_W = $clog2(LINE_MAX);

  char_t            line_store [LINE_MAX];
  logic [POS_W-1:0] char_position;
  logic [2:0]       led_bits;

  logic [POS_W-1:0] pos;
  logic             ends;
  char_t            line_now [LINE_MAX];
  logic [CMD_COUNT-1:0] cmd_hit;
  logic [2:0]       led_next;
  logic [1:0]       need;

  always_comb begin
    if ({1'b0, char_position} >= (POS_W+1)'(LINE_MAX)) begin
      pos = '0;
    end else begin
      pos = char_position;
    end
  end

  assign ends = (item_byte == CH_CR) || (({1'b0, pos} + 1'b1) >= (POS_W+1)'(LINE_MAX));

  always_comb begin
    for (int i = 0; i < LINE_MAX; i++) begin
      line_now[i] = (pos == POS_W'(i)) ? item_byte : line_store[i];
    end
  end

  for (genvar j = 0; j < CMD_COUNT; j++) begin : g_cmd
    logic [CMD_WORD_MAX-1:0] pos_ok;
    for (genvar k = 0; k < CMD_WORD_MAX; k++) begin : g_chr
      if (k >= CMD_LEN[j]) begin : g_pad
        assign pos_ok[k] = 1'b1;
      end else if (k >= LINE_MAX) begin : g_short
        assign pos_ok[k] = 1'b0;
      end else begin : g_cmp
        assign pos_ok[k] = byte_fits(line_now[k], CMD_TEXT[j][k]);
      end
    end
    assign cmd_hit[j] = &pos_ok;
  end

  always_comb begin
    led_next = led_bits;
    for (int j = 0; j < CMD_COUNT; j++) begin
      if (cmd_hit[j]) begin
        if (CMD_ON[j]) begin
          led_next = CMD_MASK[j];
        end else begin
          led_next = led_next & ~CMD_MASK[j];
        end
      end
    end
  end

  assign need = ends ? 2'd2 : 2'd1;
  assign take = item_valid && (free >= need);

  always_comb begin
    push.n                = take ? need : 2'd0;
    push.first.out_byte   = item_byte;
    push.first.led_red    = led_bits[0];
    push.first.led_blue   = led_bits[1];
    push.first.led_green  = led_bits[2];
    push.first.last       = !ends;
    push.second.out_byte  = CH_LF;
    push.second.led_red   = led_next[0];
    push.second.led_blue  = led_next[1];
    push.second.led_green = led_next[2];
    push.second.last      = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < LINE_MAX; i++) begin
        line_store[i] <= '0;
      end
      char_position <= '0;
      led_bits      <= '0;
    end else if (take) begin
      line_store[pos] <= item_byte;
      if (ends) begin
        char_position <= '0;
        led_bits      <= led_next;
      end else begin
        char_position <= pos + 1'b1;
      end
    end
  end

endmodule

/* rtl/core/ulcm_out_queue.sv */
// Two-entry result queue in front of the transmit channel; holds the
// echo and line feed of one line end together.
// Depends on ulcm_pkg.
module ulcm_out_queue import ulcm_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  ulcm_push_t   push,
  output logic [1:0]   free,
  output logic         out_valid,
  input  logic         out_ready,
  output ulcm_result_t out_item
);

  logic [1:0]   count;
  logic [1:0]   count_next;
  ulcm_result_t res0;
  ulcm_result_t res1;
  ulcm_result_t res0_next;
  ulcm_result_t res1_next;
  logic         pop;
  logic [1:0]   base;

  assign out_valid = (count != 2'd0);
  assign out_item  = res0;
  assign pop       = out_valid && out_ready;
  assign base      = count - {1'b0, pop};
  assign free      = 2'd2 - base;

  always_comb begin
    res0_next = pop ? res1 : res0;
    res1_next = res1;
    case (push.n)
      2'd1: begin
        if (base == 2'd0) begin
          res0_next = push.first;
        end else begin
          res1_next = push.first;
        end
      end
      2'd2: begin
        res0_next = push.first;
        res1_next = push.second;
      end
      default: begin
      end
    endcase
    count_next = base + push.n;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    res0 <= res0_next;
    res1 <= res1_next;
  end

endmodule

/* rtl/core/uart_led_command_matcher_unit.sv */
// Top level of the serial LED command matcher.
// Depends on ulcm_pkg, ulcm_in_if, ulcm_out_if, ulcm_in_stage,
// ulcm_line_core and ulcm_out_queue.
//
//   channel  dir  payload                                        items
//   rx       in   rx_byte                                        one per received byte
//   tx       out  out_byte, led_red, led_blue, led_green, last   one or two per rx item
//
// An rx item is registered, then matched and turned into results once the result queue has room.
// A byte that does not end a line gives one tx item; a line end gives two, the echo and a line feed.
// Reset clears the line buffer, the write position and the LEDs.
// A stalled tx side fills the two-entry result queue, after which rx stalls.
module uart_led_command_matcher_unit import ulcm_pkg::*; #(
  parameter int LINE_MAX = LINE_MAX_DEF
) (
  input logic        clk,
  input logic        rst,
  ulcm_in_if.sink    rx,
  ulcm_out_if.source tx
);

  logic         take;
  logic         item_valid;
  char_t        item_byte;
  logic [1:0]   free;
  ulcm_push_t   push;
  ulcm_result_t out_item;

  ulcm_in_stage u_in_stage (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (rx.valid),
    .in_ready   (rx.ready),
    .in_byte    (rx.rx_byte),
    .take       (take),
    .item_valid (item_valid),
    .item_byte  (item_byte)
  );

  ulcm_line_core #(
    .LINE_MAX (LINE_MAX)
  ) u_line_core (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_byte  (item_byte),
    .free       (free),
    .take       (take),
    .push       (push)
  );

  ulcm_out_queue u_out_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .free      (free),
    .out_valid (tx.valid),
    .out_ready (tx.ready),
    .out_item  (out_item)
  );

  assign tx.out_byte  = out_item.out_byte;
  assign tx.led_red   = out_item.led_red;
  assign tx.led_blue  = out_item.led_blue;
  assign tx.led_green = out_item.led_green;
  assign tx.last      = out_item.last;

endmodule

/* tb/sv/uart_led_command_matcher_unit_tb.sv */
// Self-checking testbench for uart_led_command_matcher_unit: random and directed command
// lines with random idling on both channels, checked item by item against a predictor.
// Depends on ulcm_pkg, ulcm_in_if, ulcm_out_if and the unit itself.
module uart_led_command_matcher_unit_tb import ulcm_pkg::*; ;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LINE_LEN    = LINE_MAX_DEF;
  localparam int QUIET_LIMIT = 2000;
  localparam int PHASE_ITEMS = 234;
  localparam int HOLD_AFTER  = 100;
  localparam int HOLD_CYCLES = 60;

  typedef enum int {ON_RED, ON_BLUE, ON_GREEN, OFF_RED, OFF_BLUE, OFF_GREEN} command_t;

  logic clk;
  logic rst;

  ulcm_in_if  rx_ch ();
  ulcm_out_if tx_ch ();

  uart_led_command_matcher_unit #(.LINE_MAX(LINE_LEN)) DUT (
    .clk(clk),
    .rst(rst),
    .rx (rx_ch),
    .tx (tx_ch)
  );

  char_t        line_buf [LINE_LEN];
  logic [3:0]   wr_pos;
  logic [2:0]   led_state;
  ulcm_result_t expected_results [$];
  char_t        rx_pending [$];

  logic rx_taken = 1'b0;
  int   quiet_cycles = 0;
  int   error_count = 0;
  int   tx_count = 0;
  int   sender_idle_pct = 0;
  int   receiver_idle_pct = 0;
  int   hold_left = 0;
  logic hold_done = 1'b0;

  initial begin
    clk = 1'b0;
    rst = 1'b1;
    rx_ch.valid = 1'b0;
    rx_ch.rx_byte = 8'd0;
    tx_ch.ready = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic string cmd_word(input command_t c);
    case (c)
      ON_RED:    return "on red";
      ON_BLUE:   return "on blue";
      ON_GREEN:  return "on green";
      OFF_RED:   return "off red";
      OFF_BLUE:  return "off blue";
      default:   return "off green";
    endcase
  endfunction

  function automatic logic [2:0] cmd_led(input command_t c);
    case (c)
      ON_RED, OFF_RED:   return LED_RED;
      ON_BLUE, OFF_BLUE: return LED_BLUE;
      default:           return LED_GREEN;
    endcase
  endfunction

  // Letters in a command match either case; the space and all else must be exact.
  function automatic logic line_starts_with(input string w);
    char_t p;
    char_t c;
    logic  hit;
    hit = 1'b1;
    for (int k = 0; k < w.len(); k++) begin
      if (k >= LINE_LEN) begin
        hit = 1'b0;
      end else begin
        p = w[k];
        c = line_buf[k];
        if (p >= "a" && p <= "z") begin
          c = c | CASE_BIT;
        end
        if (c != p) begin
          hit = 1'b0;
        end
      end
    end
    return hit;
  endfunction

  task automatic push_led_result(input char_t b, input logic fin);
    ulcm_result_t r;
    r.out_byte  = b;
    r.led_red   = led_state[0];
    r.led_blue  = led_state[1];
    r.led_green = led_state[2];
    r.last      = fin;
    expected_results.push_back(r);
  endtask

  task automatic predict_byte(input char_t b);
    int unsigned pos;
    logic        line_end;
    command_t    c;
    pos = wr_pos;
    if (pos >= LINE_LEN) begin
      pos = 0;
    end
    line_buf[pos] = b;
    line_end = (b == CH_CR) || (pos + 1 >= LINE_LEN);
    push_led_result(b, !line_end);
    if (line_end) begin
      for (int i = 0; i <= OFF_GREEN; i++) begin
        c = command_t'(i);
        if (line_starts_with(cmd_word(c))) begin
          if (c <= ON_GREEN) begin
            led_state = cmd_led(c);
          end else begin
            led_state = led_state & ~cmd_led(c);
          end
        end
      end
      wr_pos = 4'd0;
      push_led_result(CH_LF, 1'b1);
    end else begin
      wr_pos = 4'(pos + 1);
    end
  endtask

  task automatic report_mismatch(input string msg);
    $display("mismatch at %0t: %s", $realtime, msg);
    error_count++;
  endtask

  task automatic check_result();
    ulcm_result_t want;
    tx_count++;
    if (expected_results.size() == 0) begin
      report_mismatch($sformatf("unexpected item, out_byte %0d", tx_ch.out_byte));
    end else begin
      want = expected_results.pop_front();
      if (tx_ch.out_byte !== want.out_byte)
        report_mismatch($sformatf("out_byte %0d, want %0d", tx_ch.out_byte, want.out_byte));
      if (tx_ch.led_red !== want.led_red)
        report_mismatch($sformatf("led_red %b, want %b", tx_ch.led_red, want.led_red));
      if (tx_ch.led_blue !== want.led_blue)
        report_mismatch($sformatf("led_blue %b, want %b", tx_ch.led_blue, want.led_blue));
      if (tx_ch.led_green !== want.led_green)
        report_mismatch($sformatf("led_green %b, want %b", tx_ch.led_green, want.led_green));
      if (tx_ch.last !== want.last)
        report_mismatch($sformatf("last %b, want %b", tx_ch.last, want.last));
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      rx_taken <= 1'b0;
      quiet_cycles <= 0;
    end else begin
      rx_taken <= rx_ch.valid && rx_ch.ready;
      if (rx_ch.valid && rx_ch.ready) begin
        predict_byte(rx_ch.rx_byte);
      end
      if (tx_ch.valid && tx_ch.ready) begin
        check_result();
      end
      if ((rx_ch.valid && rx_ch.ready) || (tx_ch.valid && tx_ch.ready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
        $display("RESULT: ERROR");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  always @(negedge clk) begin
    if (rst) begin
      rx_ch.valid <= 1'b0;
    end else if (!rx_ch.valid || rx_taken) begin
      if (rx_pending.size() > 0 && $urandom_range(99, 0) >= sender_idle_pct) begin
        rx_ch.valid <= 1'b1;
        rx_ch.rx_byte <= rx_pending.pop_front();
      end else begin
        rx_ch.valid <= 1'b0;
      end
    end
  end

  // The long hold-off lets the result queue fill so that the input side stalls.
  always @(negedge clk) begin
    if (rst) begin
      tx_ch.ready <= 1'b0;
    end else if (hold_left > 0) begin
      tx_ch.ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (!hold_done && tx_count >= HOLD_AFTER) begin
      tx_ch.ready <= 1'b0;
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end else begin
      tx_ch.ready <= ($urandom_range(99, 0) >= receiver_idle_pct);
    end
  end

  task automatic push_text(input string s);
    for (int k = 0; k < s.len(); k++) begin
      rx_pending.push_back(char_t'(s[k]));
    end
  endtask

  // Mostly command lines with random case, some cut short, broken or padded,
  // and the rest bare line ends and noise.
  task automatic queue_line();
    int       kind;
    int       n;
    command_t c;
    string    w;
    char_t    ch;
    char_t    line_q [$];
    kind = $urandom_range(99, 0);
    if (kind < 85) begin
      c = command_t'($urandom_range(OFF_GREEN, ON_RED));
      w = cmd_word(c);
      for (int k = 0; k < w.len(); k++) begin
        ch = w[k];
        if (ch >= "a" && ch <= "z" && $urandom_range(1, 0) == 1) begin
          ch = ch & ~CASE_BIT;
        end
        line_q.push_back(ch);
      end
      if (kind < 10) begin
        line_q[$urandom_range(line_q.size() - 1, 0)] = char_t'($urandom_range(255, 0));
      end else if (kind < 25) begin
        n = $urandom_range(line_q.size() - 1, 0);
        while (line_q.size() > n) begin
          line_q.pop_back();
        end
      end
      if (kind % 2 == 0) begin
        n = $urandom_range(LINE_LEN - line_q.size(), 0);
        repeat (n) line_q.push_back(char_t'($urandom_range(255, 0)));
      end
      if (line_q.size() < LINE_LEN) begin
        line_q.push_back(CH_CR);
      end
    end else if (kind < 92) begin
      line_q.push_back(CH_CR);
    end else begin
      repeat ($urandom_range(12, 1)) line_q.push_back(char_t'($urandom_range(255, 0)));
    end
    foreach (line_q[k]) begin
      rx_pending.push_back(line_q[k]);
    end
  endtask

  task automatic wait_drained();
    while (rx_pending.size() != 0 || rx_ch.valid) @(posedge clk);
    while (expected_results.size() != 0) @(posedge clk);
  endtask

  initial begin
    foreach (line_buf[k]) begin
      line_buf[k] = 8'd0;
    end
    wr_pos = 4'd0;
    led_state = 3'd0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    sender_idle_pct = 28;
    receiver_idle_pct = 58;
    push_text("On ReD");
    rx_pending.push_back(CH_CR);
    push_text("OFF REDx");
    rx_pending.push_back(8'h00);
    rx_pending.push_back(8'hFF);
    push_text("oN GrEeN");
    rx_pending.push_back(CH_CR);

    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin sender_idle_pct = 28; receiver_idle_pct = 58; end
        1: begin sender_idle_pct = 58; receiver_idle_pct = 28; end
        default: begin sender_idle_pct = 0; receiver_idle_pct = 0; end
      endcase
      while (rx_pending.size() < PHASE_ITEMS) queue_line();
      wait_drained();
    end

    repeat (10) @(posedge clk);
    if (error_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

/* sim.f */
rtl/core/ulcm_pkg.sv
rtl/core/ulcm_in_if.sv
rtl/core/ulcm_out_if.sv
rtl/core/ulcm_in_stage.sv
rtl/core/ulcm_line_core.sv
rtl/core/ulcm_out_queue.sv
rtl/core/uart_led_command_matcher_unit.sv
tb/sv/uart_led_command_matcher_unit_tb.sv
